// ===== sv/u8am_pkg.sv =====
// u8am_pkg: shared types and constants of the utf-8 to code-page converter
// no dependencies; imported by every module of the block
`default_nettype none

package u8am_pkg;

	// input command codes
	localparam logic CMD_MAP_WRITE = 1'b0;
	localparam logic CMD_BYTE      = 1'b1;

	// configuration register indexes (paddr[2])
	localparam logic REG_REPL   = 1'b0;
	localparam logic REG_STRICT = 1'b1;

	localparam logic [7:0]  REPL_RESET = 8'd63;
	localparam logic [7:0]  ASCII_MAX  = 8'h7f;
	localparam logic [15:0] CP_FFFD    = 16'hfffd;

	// continuation range rule of the next byte
	localparam logic [2:0] CLS_NONE = 3'd0;
	localparam logic [2:0] CLS_ANY  = 3'd1;
	localparam logic [2:0] CLS_E0   = 3'd2;
	localparam logic [2:0] CLS_ED   = 3'd3;
	localparam logic [2:0] CLS_F0   = 3'd4;
	localparam logic [2:0] CLS_F4   = 3'd5;

	// source of one result character
	typedef enum logic [1:0] {
		K_ASCII = 2'd0,
		K_FFFD  = 2'd1,
		K_CP    = 2'd2
	} kind_t;

	// decoded byte waiting for its map lookup
	typedef struct packed {
		logic [1:0] n;
		kind_t      k0;
		kind_t      k1;
		logic [6:0] asc;
		logic       cp_zero;
		logic       eos;
	} item_t;

	// strict failure feedback from the output stage to the decoder
	typedef struct packed {
		logic active;
		logic eos;
	} fail_t;

	function automatic logic cont_ok(input logic [2:0] cls, input logic [7:0] b);
		logic ok;
		case (cls)
			CLS_E0:  ok = (b >= 8'ha0) && (b <= 8'hbf);
			CLS_ED:  ok = (b >= 8'h80) && (b <= 8'h9f);
			CLS_F0:  ok = (b >= 8'h90) && (b <= 8'hbf);
			CLS_F4:  ok = (b >= 8'h80) && (b <= 8'h8f);
			default: ok = (b >= 8'h80) && (b <= 8'hbf);
		endcase
		return ok;
	endfunction

endpackage

`default_nettype wire

// ===== sv/u8am_if.sv =====
// u8am_in_if / u8am_out_if: valid-ready channels of the converter
// no dependencies
`default_nettype none

interface u8am_in_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [15:0] map_index;
	logic [7:0]  map_value;
	logic [7:0]  data_byte;
	logic        end_of_string;

	modport source(output valid, command, map_index, map_value, data_byte, end_of_string,
		input ready);
	modport sink(input valid, command, map_index, map_value, data_byte, end_of_string,
		output ready);
endinterface

interface u8am_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] ansi_char;
	logic       unmappable;
	logic       last_char;

	modport source(output valid, ansi_char, unmappable, last_char, input ready);
	modport sink(input valid, ansi_char, unmappable, last_char, output ready);
endinterface

`default_nettype wire

// ===== sv/u8am_cfg.sv =====
// u8am_cfg: apb register file (replacement character, strict mode)
// depends on u8am_pkg
`default_nettype none

module u8am_cfg
	import u8am_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output logic      [7:0]  repl,
	output logic             strict
);

	logic       wr;
	logic [7:0] repl_q;
	logic       strict_q;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repl_q   <= REPL_RESET;
			strict_q <= 1'b0;
		end else if (wr) begin
			case (paddr[2])
				REG_REPL:   repl_q   <= pwdata[7:0];
				REG_STRICT: strict_q <= pwdata[0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_REPL:   prdata = {24'd0, repl_q};
			REG_STRICT: prdata = {31'd0, strict_q};
			default:    prdata = 32'd0;
		endcase
	end

	assign repl   = repl_q;
	assign strict = strict_q;

endmodule

`default_nettype wire

// ===== sv/u8am_map.sv =====
// u8am_map: character map memory, one write and one registered read per cycle
// keeps a copy of the u+fffd entry; depends on u8am_pkg
`default_nettype none

module u8am_map
	import u8am_pkg::*;
#(
	parameter int MAP_INDEX_BITS = 16
) (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [15:0]               wr_index,
	input  wire logic [7:0]                wr_value,
	input  wire logic                      re,
	input  wire logic [MAP_INDEX_BITS-1:0] rd_addr,
	output logic      [7:0]                rdata,
	output logic      [7:0]                fffd_entry
);

	localparam int  DEPTH       = 1 << MAP_INDEX_BITS;
	localparam bit  FFFD_IN_MAP = (MAP_INDEX_BITS >= 16);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;
	logic [7:0] fffd_q;
	logic       in_range;

	assign in_range = ((32'(wr_index) >> MAP_INDEX_BITS) == 32'd0);

	always_ff @(posedge clk) begin
		if (we && in_range) begin
			mem[wr_index[MAP_INDEX_BITS-1:0]] <= wr_value;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (we && (wr_index == CP_FFFD)) begin
			fffd_q <= wr_value;
		end
	end

	assign rdata      = rdata_q;
	assign fffd_entry = FFFD_IN_MAP ? fffd_q : 8'd0;

endmodule

`default_nettype wire

// ===== sv/u8am_dec.sv =====
// u8am_dec: utf-8 decoder state and per-byte decode, issues the map read
// depends on u8am_pkg
`default_nettype none

module u8am_dec
	import u8am_pkg::*;
#(
	parameter int MAP_INDEX_BITS = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      accept_byte,
	input  wire logic [7:0]                data_byte,
	input  wire logic                      end_of_string,
	input  wire fail_t                     fb,
	output item_t                          item,
	output logic      [MAP_INDEX_BITS-1:0] rd_addr
);

	logic [14:0] part_q;
	logic [1:0]  cont_q;
	logic [2:0]  cls_q;
	logic        drop_q;

	logic        eff_drop;
	logic [14:0] eff_part;
	logic [1:0]  eff_cont;
	logic [2:0]  eff_cls;

	logic        l_res;
	kind_t       l_kind;
	logic [14:0] l_part;
	logic [1:0]  l_cont;
	logic [2:0]  l_cls;

	logic [20:0] cp;
	logic [1:0]  r_n;
	kind_t       r_k0;
	kind_t       r_k1;
	logic [14:0] nxt_part;
	logic [1:0]  nxt_cont;
	logic [2:0]  nxt_cls;
	logic        nxt_drop;

	// a strict failure in the output stage clears the decoder at once
	assign eff_drop = fb.active ? !fb.eos : drop_q;
	assign eff_part = fb.active ? 15'd0 : part_q;
	assign eff_cont = fb.active ? 2'd0 : cont_q;
	assign eff_cls  = fb.active ? CLS_NONE : cls_q;

	always_comb begin
		l_res  = 1'b0;
		l_kind = K_FFFD;
		l_part = 15'd0;
		l_cont = 2'd0;
		l_cls  = CLS_NONE;
		if (data_byte <= ASCII_MAX) begin
			l_res  = 1'b1;
			l_kind = K_ASCII;
		end else if (data_byte >= 8'hc2 && data_byte <= 8'hdf) begin
			l_part = {10'd0, data_byte[4:0]};
			l_cont = 2'd1;
			l_cls  = CLS_ANY;
		end else if (data_byte >= 8'he0 && data_byte <= 8'hef) begin
			l_part = {11'd0, data_byte[3:0]};
			l_cont = 2'd2;
			l_cls  = (data_byte == 8'he0) ? CLS_E0 : (data_byte == 8'hed) ? CLS_ED : CLS_ANY;
		end else if (data_byte >= 8'hf0 && data_byte <= 8'hf4) begin
			l_part = {12'd0, data_byte[2:0]};
			l_cont = 2'd3;
			l_cls  = (data_byte == 8'hf0) ? CLS_F0 : (data_byte == 8'hf4) ? CLS_F4 : CLS_ANY;
		end else begin
			l_res = 1'b1;
		end
	end

	assign cp = {eff_part, data_byte[5:0]};

	always_comb begin
		r_n      = 2'd0;
		r_k0     = K_ASCII;
		r_k1     = K_ASCII;
		nxt_part = 15'd0;
		nxt_cont = 2'd0;
		nxt_cls  = CLS_NONE;
		nxt_drop = 1'b0;
		if (eff_cont != 2'd0) begin
			if (cont_ok(eff_cls, data_byte)) begin
				if (eff_cont == 2'd1) begin
					r_n  = 2'd1;
					r_k0 = K_CP;
				end else begin
					nxt_part = {eff_part[8:0], data_byte[5:0]};
					nxt_cont = eff_cont - 2'd1;
					nxt_cls  = CLS_ANY;
				end
			end else begin
				r_n      = 2'd1;
				r_k0     = K_FFFD;
				nxt_part = l_part;
				nxt_cont = l_cont;
				nxt_cls  = l_cls;
				if (l_res) begin
					r_n  = 2'd2;
					r_k1 = l_kind;
				end
			end
		end else begin
			nxt_part = l_part;
			nxt_cont = l_cont;
			nxt_cls  = l_cls;
			if (l_res) begin
				r_n  = 2'd1;
				r_k0 = l_kind;
			end
		end
		// sequence cut short by the end of the string
		if (end_of_string) begin
			if (nxt_cont != 2'd0) begin
				if (r_n == 2'd0) begin
					r_n  = 2'd1;
					r_k0 = K_FFFD;
				end else begin
					r_n  = 2'd2;
					r_k1 = K_FFFD;
				end
			end
			nxt_part = 15'd0;
			nxt_cont = 2'd0;
			nxt_cls  = CLS_NONE;
		end
		if (eff_drop) begin
			r_n      = 2'd0;
			nxt_part = 15'd0;
			nxt_cont = 2'd0;
			nxt_cls  = CLS_NONE;
			nxt_drop = !end_of_string;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_q <= 15'd0;
			cont_q <= 2'd0;
			cls_q  <= CLS_NONE;
			drop_q <= 1'b0;
		end else if (accept_byte) begin
			part_q <= nxt_part;
			cont_q <= nxt_cont;
			cls_q  <= nxt_cls;
			drop_q <= nxt_drop;
		end else if (fb.active) begin
			part_q <= 15'd0;
			cont_q <= 2'd0;
			cls_q  <= CLS_NONE;
			drop_q <= !fb.eos;
		end
	end

	assign item.n       = r_n;
	assign item.k0      = r_k0;
	assign item.k1      = r_k1;
	assign item.asc     = data_byte[6:0];
	assign item.cp_zero = ((cp >> MAP_INDEX_BITS) != 21'd0);
	assign item.eos     = end_of_string;
	assign rd_addr      = cp[MAP_INDEX_BITS-1:0];

	a_drop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		drop_q |-> (cont_q == 2'd0 && part_q == 15'd0))
		else $error("drop pending with live decoder state");

endmodule

`default_nettype wire

// ===== sv/u8am_emit.sv =====
// u8am_emit: lookup stage and output register, splits a byte into its results
// depends on u8am_pkg
`default_nettype none

module u8am_emit
	import u8am_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       load,
	input  wire item_t      item_in,
	input  wire logic [7:0] rdata,
	input  wire logic [7:0] fffd_entry,
	input  wire logic [7:0] repl,
	input  wire logic       strict,
	output fail_t           fb,
	output logic            in_free,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic      [7:0] ansi_char,
	output logic            unmappable,
	output logic            last_char
);

	item_t      item_s1;
	logic       s1_valid_q;
	logic       sel_q;

	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       out_unm_q;
	logic       out_last_q;

	logic [7:0] ch0;
	logic [7:0] ch1;
	logic       fail0;
	logic       fail1;
	logic [1:0] n_eff;
	logic       cur_fail;
	logic [7:0] cur_ch;
	logic       cur_bad;
	logic       is_last_res;
	logic       out_free;
	logic       emit;
	logic       done;

	function automatic logic [7:0] char_of(input kind_t k, input logic [6:0] asc,
		input logic cp_zero, input logic [7:0] mem_data, input logic [7:0] fffd);
		logic [7:0] c;
		case (k)
			K_ASCII: c = {1'b0, asc};
			K_FFFD:  c = fffd;
			K_CP:    c = cp_zero ? 8'd0 : mem_data;
			default: c = 8'd0;
		endcase
		return c;
	endfunction

	assign ch0   = char_of(item_s1.k0, item_s1.asc, item_s1.cp_zero, rdata, fffd_entry);
	assign ch1   = char_of(item_s1.k1, item_s1.asc, item_s1.cp_zero, rdata, fffd_entry);
	assign fail0 = strict && (item_s1.k0 != K_ASCII) && (ch0 == 8'd0);
	assign fail1 = strict && (item_s1.k1 != K_ASCII) && (ch1 == 8'd0);
	assign n_eff = ((item_s1.n != 2'd0) && fail0) ? 2'd1 : item_s1.n;

	assign fb.active = s1_valid_q && (((item_s1.n != 2'd0) && fail0) ||
		((item_s1.n == 2'd2) && fail1));
	assign fb.eos    = item_s1.eos;

	assign cur_ch   = sel_q ? ch1 : ch0;
	assign cur_fail = sel_q ? fail1 : fail0;
	assign cur_bad  = ((sel_q ? item_s1.k1 : item_s1.k0) != K_ASCII) && (cur_ch == 8'd0);

	assign is_last_res = ((n_eff == 2'd1) && !sel_q) || ((n_eff == 2'd2) && sel_q);
	assign out_free    = !out_valid_q || out_ready;
	assign emit        = s1_valid_q && (n_eff != 2'd0) && out_free;
	assign done        = s1_valid_q && ((n_eff == 2'd0) || (out_free && is_last_res));
	assign in_free     = !s1_valid_q || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			sel_q      <= 1'b0;
		end else begin
			if (load) begin
				s1_valid_q <= 1'b1;
				sel_q      <= 1'b0;
			end else if (done) begin
				s1_valid_q <= 1'b0;
				sel_q      <= 1'b0;
			end else if (emit) begin
				sel_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_char_q <= cur_fail ? 8'd0 : (cur_bad ? repl : cur_ch);
			out_unm_q  <= cur_fail;
			out_last_q <= cur_fail || (item_s1.eos && is_last_res);
		end
	end

	assign out_valid  = out_valid_q;
	assign ansi_char  = out_char_q;
	assign unmappable = out_unm_q;
	assign last_char  = out_last_q;

	a_sel_two: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && sel_q) |-> (n_eff == 2'd2))
		else $error("second result selected for a single-result beat");

	a_fail_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_unm_q) |-> (out_last_q && out_char_q == 8'd0))
		else $error("failure result not marked last");

	a_hold_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !out_free && n_eff != 2'd0) |=> (s1_valid_q && $stable(sel_q)))
		else $error("lookup stage moved while output stalled");

endmodule

`default_nettype wire

// ===== sv/utf8_to_ansi_table_map.sv =====
// utf8_to_ansi_table_map: streaming utf-8 to single-byte code page converter
// depends on u8am_pkg, u8am_if, u8am_cfg, u8am_map, u8am_dec, u8am_emit
//
// din carries beats of two kinds: a map write (command 0) stores map_value for
// code point map_index; a data beat (command 1) delivers one utf-8 byte, with
// end_of_string on the last byte of a string. dout gives one code-page
// character per decoded code point; unmappable marks a strict-mode failure,
// after which the rest of the string is swallowed up to its last byte.
// registers over apb: 0x0 replacement character, 0x4 strict mode.
// path of a byte: the map read and the lookup stage register load when it is
// accepted, then the lookup and the output register load.
// throughput: one beat per cycle while dout does not stall; a byte that yields
// two results holds din back, as the single output register takes one result per
// cycle. a beat either writes or reads the map, never both.
// reset clears the decoder and the registers (replacement 63, best-fit mode);
// map contents are undefined until written. when dout stalls, the output
// register and the lookup stage hold and din.ready drops.
`default_nettype none

module utf8_to_ansi_table_map
	import u8am_pkg::*;
#(
	parameter int MAP_INDEX_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	u8am_in_if.sink          din,
	u8am_out_if.source       dout,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	logic                      accept;
	logic                      accept_byte;
	logic                      accept_write;
	logic                      in_free;
	logic [7:0]                repl;
	logic                      strict;
	logic [7:0]                rdata;
	logic [7:0]                fffd_entry;
	logic [MAP_INDEX_BITS-1:0] rd_addr;
	item_t                     item;
	fail_t                     fb;

	assign din.ready    = in_free;
	assign accept       = din.valid && in_free;
	assign accept_byte  = accept && (din.command == CMD_BYTE);
	assign accept_write = accept && (din.command == CMD_MAP_WRITE);

	u8am_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.repl    (repl),
		.strict  (strict)
	);

	u8am_dec #(
		.MAP_INDEX_BITS (MAP_INDEX_BITS)
	) u_dec (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept_byte   (accept_byte),
		.data_byte     (din.data_byte),
		.end_of_string (din.end_of_string),
		.fb            (fb),
		.item          (item),
		.rd_addr       (rd_addr)
	);

	u8am_map #(
		.MAP_INDEX_BITS (MAP_INDEX_BITS)
	) u_map (
		.clk        (clk),
		.we         (accept_write),
		.wr_index   (din.map_index),
		.wr_value   (din.map_value),
		.re         (accept_byte),
		.rd_addr    (rd_addr),
		.rdata      (rdata),
		.fffd_entry (fffd_entry)
	);

	u8am_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (accept_byte),
		.item_in    (item),
		.rdata      (rdata),
		.fffd_entry (fffd_entry),
		.repl       (repl),
		.strict     (strict),
		.fb         (fb),
		.in_free    (in_free),
		.out_valid  (dout.valid),
		.out_ready  (dout.ready),
		.ansi_char  (dout.ansi_char),
		.unmappable (dout.unmappable),
		.last_char  (dout.last_char)
	);

endmodule

`default_nettype wire
